### design/bspa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspa_pkg
// Shared types, codes and helpers of the bitmap sub-page pool allocator.
// ----------------------------------------------------------------------------
package bspa_pkg;

    localparam int CHUNK_SLOTS  = 16;
    localparam int SLOT_BITS    = $clog2(CHUNK_SLOTS);
    localparam int ADDRESS_BITS = 48;
    localparam int COUNT_BITS   = $clog2(CHUNK_SLOTS + 1);
    localparam int STAMP_BITS   = 32;
    localparam int MAP_BITS     = 64;
    localparam int IDX_BITS     = 7;
    localparam int RATIO_BITS   = 7;
    localparam int SHIFT_BITS   = 6;
    localparam int CFG_DATA_BITS = 7;

    typedef enum logic [1:0] {
        OP_RESERVE  = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_FREE     = 2'd2,
        OP_TRIM     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_INVALID = 2'd2,
        ST_NOTHING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TAG_UNUSED  = 2'd0,
        TAG_FREE    = 2'd1,
        TAG_PARTIAL = 2'd2,
        TAG_FULL    = 2'd3
    } tag_t;

    // configuration register indexes
    localparam logic CFG_RATIO = 1'b0;
    localparam logic CFG_SHIFT = 1'b1;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 7'd64;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd12;

    typedef struct packed {
        logic [1:0]              operation;
        logic [ADDRESS_BITS-1:0] address;
        logic [SLOT_BITS-1:0]    slot;
        logic [4:0]              count_target;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [ADDRESS_BITS-1:0] result_address;
        logic [SLOT_BITS-1:0]    result_slot;
        logic [4:0]              free_count;
        logic [4:0]              partial_count;
        logic [4:0]              full_count;
    } out_item_t;

    // commands from controller to datapath
    typedef struct packed {
        logic                 capture;
        logic                 scan;
        logic [SLOT_BITS-1:0] scan_idx;
        logic                 prep;
        logic                 calc;
        logic                 commit;
    } bspa_cmd_t;

    // index of lowest set bit, MAP_BITS when none
    function automatic logic [IDX_BITS-1:0] low_set_index(input logic [MAP_BITS-1:0] v);
        logic [IDX_BITS-1:0] r;
        r = IDX_BITS'(MAP_BITS);
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r = IDX_BITS'(i);
            end
        end
        return r;
    endfunction

    // bits below the ratio
    function automatic logic [MAP_BITS-1:0] low_mask(input logic [RATIO_BITS-1:0] ratio);
        logic [MAP_BITS-1:0] m;
        if (ratio >= RATIO_BITS'(MAP_BITS))
        begin
            m = '1;
        end
        else
        begin
            m = (MAP_BITS'(1) << ratio) - MAP_BITS'(1);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

### design/bspa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspa_ctrl
// Request sequencer: accept, slot scan, operand fetch, compute, commit.
// ----------------------------------------------------------------------------
module bspa_ctrl
    import bspa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output bspa_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_CALC,
        S_COMMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic                 out_free;

    assign out_free = !valid_reg || !out_stall;

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.scan     = (state_reg == S_SCAN);
        cmd.scan_idx = idx_reg;
        cmd.prep     = (state_reg == S_PREP);
        cmd.calc     = (state_reg == S_CALC);
        cmd.commit   = (state_reg == S_COMMIT) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_BITS'(CHUNK_SLOTS - 1))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:   state_next = S_CALC;
            S_CALC:   state_next = S_COMMIT;
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    valid_next = 1'b1;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = valid_reg;

endmodule
`default_nettype wire

### design/bspa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspa_datapath
// Chunk table, list scan trackers, operand registers and result register.
// ----------------------------------------------------------------------------
module bspa_datapath
    import bspa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bspa_cmd_t                cmd,
    input  wire in_item_t                 in_data,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output out_item_t                     out_data
);

    // chunk table
    logic [ADDRESS_BITS-1:0] base_reg  [CHUNK_SLOTS];
    logic [MAP_BITS-1:0]     bits_reg  [CHUNK_SLOTS];
    tag_t                    tag_reg   [CHUNK_SLOTS];
    logic [STAMP_BITS-1:0]   stamp_reg [CHUNK_SLOTS];
    logic [STAMP_BITS-1:0]   counter_reg;
    logic [COUNT_BITS-1:0]   nfree_reg, npart_reg, nfull_reg;
    logic [RATIO_BITS-1:0]   ratio_reg;
    logic [SHIFT_BITS-1:0]   shift_reg;

    in_item_t                item_reg;
    op_t                     op;

    // scan trackers
    logic                    pfound_reg, ffound_reg, ufound_reg;
    logic [SLOT_BITS-1:0]    pidx_reg, fidx_reg, uidx_reg;
    logic [STAMP_BITS-1:0]   pstamp_reg, fstamp_reg;
    tag_t                    slot_tag_reg;

    // operands
    logic [SLOT_BITS-1:0]    sel_reg;
    logic [ADDRESS_BITS-1:0] base_q_reg, diff_q_reg;
    logic [MAP_BITS-1:0]     bits_q_reg;
    tag_t                    old_tag_reg;
    logic [IDX_BITS-1:0]     idx_q_reg;
    logic [ADDRESS_BITS-1:0] off_q_reg;

    out_item_t               out_reg;

    assign op = op_t'(item_reg.operation);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_RATIO)
            begin
                ratio_reg <= cfg_data[RATIO_BITS-1:0];
            end
            else
            begin
                shift_reg <= cfg_data[SHIFT_BITS-1:0];
            end
        end
    end

    // request capture and slot scan, one slot a cycle
    tag_t                  scan_tag;
    logic [STAMP_BITS-1:0] scan_stamp;
    assign scan_tag   = tag_reg[cmd.scan_idx];
    assign scan_stamp = stamp_reg[cmd.scan_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
            ufound_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            pfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
            ufound_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (scan_tag == TAG_PARTIAL && (!pfound_reg || scan_stamp > pstamp_reg))
            begin
                pfound_reg <= 1'b1;
            end
            if (scan_tag == TAG_FREE && (!ffound_reg || scan_stamp > fstamp_reg))
            begin
                ffound_reg <= 1'b1;
            end
            if (scan_tag == TAG_UNUSED)
            begin
                ufound_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan)
        begin
            if (scan_tag == TAG_PARTIAL && (!pfound_reg || scan_stamp > pstamp_reg))
            begin
                pidx_reg   <= cmd.scan_idx;
                pstamp_reg <= scan_stamp;
            end
            if (scan_tag == TAG_FREE && (!ffound_reg || scan_stamp > fstamp_reg))
            begin
                fidx_reg   <= cmd.scan_idx;
                fstamp_reg <= scan_stamp;
            end
            if (scan_tag == TAG_UNUSED && !ufound_reg)
            begin
                uidx_reg <= cmd.scan_idx;
            end
            if (cmd.scan_idx == item_reg.slot)
            begin
                slot_tag_reg <= scan_tag;
            end
        end
    end

    // slot selection and operand fetch
    logic [SLOT_BITS-1:0] sel_next;
    tag_t                 old_tag_next;
    always_comb
    begin
        unique case (op)
            OP_RESERVE:
            begin
                sel_next     = uidx_reg;
                old_tag_next = TAG_UNUSED;
            end
            OP_ALLOCATE:
            begin
                sel_next     = pfound_reg ? pidx_reg : fidx_reg;
                old_tag_next = pfound_reg ? TAG_PARTIAL : TAG_FREE;
            end
            OP_FREE:
            begin
                sel_next     = item_reg.slot;
                old_tag_next = slot_tag_reg;
            end
            OP_TRIM:
            begin
                sel_next     = fidx_reg;
                old_tag_next = TAG_FREE;
            end
            default:
            begin
                sel_next     = fidx_reg;
                old_tag_next = TAG_FREE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            sel_reg     <= sel_next;
            old_tag_reg <= old_tag_next;
            base_q_reg  <= base_reg[sel_next];
            bits_q_reg  <= bits_reg[sel_next];
            diff_q_reg  <= item_reg.address - base_reg[sel_next];
        end
        if (cmd.calc)
        begin
            idx_q_reg <= low_set_index(bits_q_reg);
            off_q_reg <= diff_q_reg >> shift_reg;
        end
    end

    // commit decision
    logic                    wr_tag, wr_enter, wr_base, wr_bits;
    tag_t                    new_tag;
    logic [MAP_BITS-1:0]     new_bits, mask, cleared, set_bits;
    status_t                 status;
    logic [ADDRESS_BITS-1:0] raddr, sub_addr;
    logic [SLOT_BITS-1:0]    rslot;
    logic                    off_ok;

    assign mask     = low_mask(ratio_reg);
    assign cleared  = bits_q_reg & ~(MAP_BITS'(1) << idx_q_reg[5:0]);
    assign set_bits = bits_q_reg | (MAP_BITS'(1) << off_q_reg[5:0]);
    assign sub_addr = base_q_reg
                    + (ADDRESS_BITS'(idx_q_reg[5:0]) << shift_reg);
    assign off_ok   = (off_q_reg < ADDRESS_BITS'(MAP_BITS))
                    && (off_q_reg < ADDRESS_BITS'(ratio_reg))
                    && !bits_q_reg[off_q_reg[5:0]];

    always_comb
    begin
        wr_tag   = 1'b0;
        wr_enter = 1'b0;
        wr_base  = 1'b0;
        wr_bits  = 1'b0;
        new_tag  = TAG_UNUSED;
        new_bits = '1;
        status   = ST_OK;
        raddr    = '0;
        rslot    = '0;
        unique case (op)
            OP_RESERVE:
            begin
                if (nfree_reg >= item_reg.count_target)
                begin
                    status = ST_NOTHING;
                end
                else if (!ufound_reg)
                begin
                    status = ST_NOMEM;
                end
                else
                begin
                    wr_tag   = 1'b1;
                    wr_enter = 1'b1;
                    wr_base  = 1'b1;
                    wr_bits  = 1'b1;
                    new_tag  = TAG_FREE;
                    new_bits = '1;
                    raddr    = item_reg.address;
                    rslot    = sel_reg;
                end
            end
            OP_ALLOCATE:
            begin
                if (pfound_reg)
                begin
                    if (idx_q_reg >= ratio_reg || idx_q_reg == IDX_BITS'(MAP_BITS))
                    begin
                        wr_tag   = 1'b1;
                        wr_enter = 1'b1;
                        new_tag  = TAG_FULL;
                        status   = ST_INVALID;
                    end
                    else
                    begin
                        wr_bits  = 1'b1;
                        new_bits = cleared;
                        if ((cleared & mask) == '0)
                        begin
                            wr_tag   = 1'b1;
                            wr_enter = 1'b1;
                            new_tag  = TAG_FULL;
                        end
                        raddr = sub_addr;
                        rslot = sel_reg;
                    end
                end
                else if (ffound_reg)
                begin
                    wr_bits  = 1'b1;
                    new_bits = ~MAP_BITS'(1);
                    wr_tag   = 1'b1;
                    wr_enter = 1'b1;
                    new_tag  = ((~MAP_BITS'(1) & mask) == '0) ? TAG_FULL : TAG_PARTIAL;
                    raddr    = base_q_reg;
                    rslot    = sel_reg;
                end
                else
                begin
                    status = ST_NOMEM;
                end
            end
            OP_FREE:
            begin
                if (old_tag_reg == TAG_UNUSED || !off_ok)
                begin
                    status = ST_INVALID;
                end
                else
                begin
                    wr_bits  = 1'b1;
                    new_bits = set_bits;
                    if (old_tag_reg == TAG_FULL)
                    begin
                        wr_tag   = 1'b1;
                        wr_enter = 1'b1;
                        new_tag  = (set_bits == '1) ? TAG_FREE : TAG_PARTIAL;
                    end
                    else if (old_tag_reg == TAG_PARTIAL && set_bits == '1)
                    begin
                        wr_tag   = 1'b1;
                        wr_enter = 1'b1;
                        new_tag  = TAG_FREE;
                    end
                end
            end
            OP_TRIM:
            begin
                if (nfree_reg <= item_reg.count_target)
                begin
                    status = ST_NOTHING;
                end
                else
                begin
                    wr_tag  = 1'b1;
                    new_tag = TAG_UNUSED;
                    raddr   = base_q_reg;
                    rslot   = sel_reg;
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    // list counts after the tag move
    logic [COUNT_BITS-1:0] nfree_next, npart_next, nfull_next;
    always_comb
    begin
        nfree_next = nfree_reg;
        npart_next = npart_reg;
        nfull_next = nfull_reg;
        if (wr_tag)
        begin
            if (old_tag_reg == TAG_FREE)    nfree_next = nfree_next - 1'b1;
            if (old_tag_reg == TAG_PARTIAL) npart_next = npart_next - 1'b1;
            if (old_tag_reg == TAG_FULL)    nfull_next = nfull_next - 1'b1;
            if (new_tag == TAG_FREE)        nfree_next = nfree_next + 1'b1;
            if (new_tag == TAG_PARTIAL)     npart_next = npart_next + 1'b1;
            if (new_tag == TAG_FULL)        nfull_next = nfull_next + 1'b1;
        end
    end

    // control state of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            nfree_reg   <= '0;
            npart_reg   <= '0;
            nfull_reg   <= '0;
            for (int i = 0; i < CHUNK_SLOTS; i++)
            begin
                tag_reg[i]   <= TAG_UNUSED;
                stamp_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            nfree_reg <= nfree_next;
            npart_reg <= npart_next;
            nfull_reg <= nfull_next;
            if (wr_tag)
            begin
                tag_reg[sel_reg] <= new_tag;
            end
            if (wr_enter)
            begin
                counter_reg        <= counter_reg + 1'b1;
                stamp_reg[sel_reg] <= counter_reg + 1'b1;
            end
        end
    end

    // payload of the table and result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (wr_base)
            begin
                base_reg[sel_reg] <= item_reg.address;
            end
            if (wr_bits)
            begin
                bits_reg[sel_reg] <= new_bits;
            end
            out_reg.status         <= status;
            out_reg.result_address <= raddr;
            out_reg.result_slot    <= rslot;
            out_reg.free_count     <= nfree_next;
            out_reg.partial_count  <= npart_next;
            out_reg.full_count     <= nfull_next;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

### design/bitmap_subpage_pool_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_subpage_pool_allocator_core
// Sixteen-slot chunk table with per-chunk sub-page bitmaps and free, partial
// and full lists ordered most-recent-first.
// ----------------------------------------------------------------------------
// Each request is accepted, then the sixteen chunk slots are scanned one per
// cycle for the list heads and a free slot, then operand fetch, compute and
// commit follow. A new request is accepted the cycle after commit, while the
// previous result still waits in the output register. Configuration must be
// written by the user only while no request is in flight; the block itself
// does not enforce this.
module bitmap_subpage_pool_allocator_core
    import bspa_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire in_item_t                 in_data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output out_item_t                     out_data,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    bspa_cmd_t cmd;

    bspa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    bspa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    // commit only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || !out_stall))
        else $error("commit while result register is occupied");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request accepted while busy");

    // lists never hold more chunks than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((7'(out_data.free_count) + 7'(out_data.partial_count)
                        + 7'(out_data.full_count)) <= 7'(CHUNK_SLOTS)))
        else $error("list counts exceed table size");

endmodule
`default_nettype wire

### dv/bspa_pool_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bspa_pool_checker
// Watches the request, result and register ports of the pool allocator,
// keeps its own copy of the chunk table and lists, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bspa_pool_checker
    import bspa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  in_item_t                 in_data,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  out_item_t                out_data,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       errors,
    output int                       pending,
    output int                       n_results,
    output int                       n_nomem,
    output int                       n_invalid,
    output int                       n_nothing
);

    // shadow of the chunk table
    logic [ADDRESS_BITS-1:0] base_tbl [CHUNK_SLOTS];
    logic [MAP_BITS-1:0]     map_tbl  [CHUNK_SLOTS];
    tag_t                    tag_tbl  [CHUNK_SLOTS];
    logic [STAMP_BITS-1:0]   stamp_tbl[CHUNK_SLOTS];
    logic [STAMP_BITS-1:0]   stamp_now;
    logic [RATIO_BITS-1:0]   ratio;
    logic [SHIFT_BITS-1:0]   shift;

    out_item_t expected_results[$];

    assign pending = expected_results.size();

    function automatic int lowest_free(input logic [MAP_BITS-1:0] v);
        int r;
        r = MAP_BITS;
        for (int i = MAP_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = i;
            end
        end
        return r;
    endfunction

    function automatic int list_head(input tag_t t);
        int best;
        best = -1;
        for (int s = 0; s < CHUNK_SLOTS; s++)
        begin
            if (tag_tbl[s] == t && (best < 0 || stamp_tbl[s] > stamp_tbl[best]))
            begin
                best = s;
            end
        end
        return best;
    endfunction

    function automatic logic [4:0] list_size(input tag_t t);
        logic [4:0] n;
        n = '0;
        for (int s = 0; s < CHUNK_SLOTS; s++)
        begin
            if (tag_tbl[s] == t)
            begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic move_to_list(input int s, input tag_t t);
        stamp_now    = stamp_now + 1'b1;
        tag_tbl[s]   = t;
        stamp_tbl[s] = stamp_now;
    endtask

    // one request applied to the shadow table
    task automatic predict_pool_step(input in_item_t req, output out_item_t res);
        int                      h;
        int                      idx;
        logic [ADDRESS_BITS-1:0] offs;
        logic [63:0]             wide;
        logic [4:0]              nfree;
        res   = '0;
        nfree = list_size(TAG_FREE);
        h     = -1;
        res.status = ST_OK;
        case (op_t'(req.operation))
            OP_RESERVE:
            begin
                if (nfree >= req.count_target)
                begin
                    res.status = ST_NOTHING;
                end
                else
                begin
                    for (int s = CHUNK_SLOTS - 1; s >= 0; s--)
                    begin
                        if (tag_tbl[s] == TAG_UNUSED)
                        begin
                            h = s;
                        end
                    end
                    if (h < 0)
                    begin
                        res.status = ST_NOMEM;
                    end
                    else
                    begin
                        base_tbl[h] = req.address;
                        map_tbl[h]  = '1;
                        move_to_list(h, TAG_FREE);
                        res.result_address = req.address;
                        res.result_slot    = SLOT_BITS'(h);
                    end
                end
            end
            OP_ALLOCATE:
            begin
                h = list_head(TAG_PARTIAL);
                if (h >= 0)
                begin
                    idx = lowest_free(map_tbl[h]);
                    if (idx >= ratio || idx >= MAP_BITS)
                    begin
                        move_to_list(h, TAG_FULL);
                        res.status = ST_INVALID;
                    end
                    else
                    begin
                        map_tbl[h][idx] = 1'b0;
                        if (lowest_free(map_tbl[h]) >= ratio)
                        begin
                            move_to_list(h, TAG_FULL);
                        end
                        wide = 64'(idx) << shift;
                        res.result_address = base_tbl[h] + wide[ADDRESS_BITS-1:0];
                        res.result_slot    = SLOT_BITS'(h);
                    end
                end
                else
                begin
                    h = list_head(TAG_FREE);
                    if (h < 0)
                    begin
                        res.status = ST_NOMEM;
                    end
                    else
                    begin
                        map_tbl[h] = ~64'd1;
                        move_to_list(h, (lowest_free(map_tbl[h]) >= ratio) ?
                                        TAG_FULL : TAG_PARTIAL);
                        res.result_address = base_tbl[h];
                        res.result_slot    = SLOT_BITS'(h);
                    end
                end
            end
            OP_FREE:
            begin
                h = req.slot;
                if (tag_tbl[h] == TAG_UNUSED)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    offs = req.address - base_tbl[h];
                    offs = offs >> shift;
                    if (offs >= MAP_BITS || offs >= ratio || map_tbl[h][offs[5:0]])
                    begin
                        res.status = ST_INVALID;
                    end
                    else
                    begin
                        map_tbl[h][offs[5:0]] = 1'b1;
                        if (tag_tbl[h] == TAG_FULL)
                        begin
                            move_to_list(h, (&map_tbl[h]) ? TAG_FREE : TAG_PARTIAL);
                        end
                        else if (tag_tbl[h] == TAG_PARTIAL && (&map_tbl[h]))
                        begin
                            move_to_list(h, TAG_FREE);
                        end
                    end
                end
            end
            default:
            begin
                if (nfree <= req.count_target)
                begin
                    res.status = ST_NOTHING;
                end
                else
                begin
                    h = list_head(TAG_FREE);
                    res.result_address = base_tbl[h];
                    res.result_slot    = SLOT_BITS'(h);
                    tag_tbl[h] = TAG_UNUSED;
                end
            end
        endcase
        res.free_count    = list_size(TAG_FREE);
        res.partial_count = list_size(TAG_PARTIAL);
        res.full_count    = list_size(TAG_FULL);
    endtask

    // predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t exp_res;
        out_item_t got;
        if (!rst_n)
        begin
            for (int s = 0; s < CHUNK_SLOTS; s++)
            begin
                base_tbl[s]  = '0;
                map_tbl[s]   = '0;
                tag_tbl[s]   = TAG_UNUSED;
                stamp_tbl[s] = '0;
            end
            stamp_now = '0;
            ratio     = RATIO_RESET;
            shift     = SHIFT_RESET;
            errors    = 0;
            n_results = 0;
            n_nomem   = 0;
            n_invalid = 0;
            n_nothing = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_RATIO)
                begin
                    ratio = cfg_data[RATIO_BITS-1:0];
                end
                else
                begin
                    shift = cfg_data[SHIFT_BITS-1:0];
                end
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                n_results++;
                if (got.status == ST_NOMEM)   n_nomem++;
                if (got.status == ST_INVALID) n_invalid++;
                if (got.status == ST_NOTHING) n_nothing++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (got.status != exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, got.status);
                        errors++;
                    end
                    if (got.result_address != exp_res.result_address)
                    begin
                        $error("result_address: expected %h, got %h",
                               exp_res.result_address, got.result_address);
                        errors++;
                    end
                    if (got.result_slot != exp_res.result_slot)
                    begin
                        $error("result_slot: expected %0d, got %0d",
                               exp_res.result_slot, got.result_slot);
                        errors++;
                    end
                    if (got.free_count != exp_res.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               exp_res.free_count, got.free_count);
                        errors++;
                    end
                    if (got.partial_count != exp_res.partial_count)
                    begin
                        $error("partial_count: expected %0d, got %0d",
                               exp_res.partial_count, got.partial_count);
                        errors++;
                    end
                    if (got.full_count != exp_res.full_count)
                    begin
                        $error("full_count: expected %0d, got %0d",
                               exp_res.full_count, got.full_count);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_pool_step(in_data, exp_res);
                expected_results.push_back(exp_res);
            end
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Request stimulus for the bitmap sub-page pool allocator: a directed opening,
// then random reserve, allocate, free and trim requests over several ratio
// and sub-page size settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import bspa_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 280;
    localparam int STALL_LIMIT = 5000;
    localparam int LIVE_MAX    = 64;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    out_item_t                out_data;
    logic                     cfg_write;
    logic                     cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int errors;
    int pending;
    int n_results;
    int n_nomem;
    int n_invalid;
    int n_nothing;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int op_sent[4];
    int cur_shift;

    // requests in flight and sub-pages handed out
    op_t                     ops_in_flight[$];
    logic [SLOT_BITS-1:0]    live_slot[$];
    logic [ADDRESS_BITS-1:0] live_addr[$];

    bitmap_subpage_pool_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bspa_pool_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .n_results (n_results),
        .n_nomem   (n_nomem),
        .n_invalid (n_invalid),
        .n_nothing (n_nothing)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // remember allocated sub-pages for later frees
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall && ops_in_flight.size() != 0)
        begin
            if (ops_in_flight.pop_front() == OP_ALLOCATE && out_data.status == ST_OK)
            begin
                live_slot.push_back(out_data.result_slot);
                live_addr.push_back(out_data.result_address);
                if (live_slot.size() > LIVE_MAX)
                begin
                    void'(live_slot.pop_front());
                    void'(live_addr.pop_front());
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input op_t op, input logic [ADDRESS_BITS-1:0] addr,
                        input logic [SLOT_BITS-1:0] slot, input logic [4:0] tgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_data.operation     <= op;
        in_data.address       <= addr;
        in_data.slot          <= slot;
        in_data.count_target  <= tgt;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ops_in_flight.push_back(op);
        op_sent[op]++;
        @(negedge clk);
    endtask

    // drain, let the last request settle, then write both registers
    task automatic set_config(input int ratio_val, input int shift_val);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_RATIO;
        cfg_data  <= CFG_DATA_BITS'(ratio_val);
        @(negedge clk);
        cfg_index <= CFG_SHIFT;
        cfg_data  <= CFG_DATA_BITS'(shift_val);
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_shift = shift_val;
    endtask

    function automatic logic [ADDRESS_BITS-1:0] rand_addr();
        return ADDRESS_BITS'({$urandom, $urandom});
    endfunction

    task automatic send_random();
        int                      pick;
        int                      k;
        logic [ADDRESS_BITS-1:0] a;
        logic [63:0]             span;
        pick = $urandom_range(99);
        span = (64'd1 << cur_shift) - 1;
        if (pick < 22)
        begin
            a = rand_addr();
            case ($urandom_range(3))
                0: a = '0;
                1: a = '1;
                2: a = a & ~span[ADDRESS_BITS-1:0];
                default: ;
            endcase
            send(OP_RESERVE, a, SLOT_BITS'($urandom),
                 ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(16)));
        end
        else if (pick < 58)
        begin
            send(OP_ALLOCATE, rand_addr(), SLOT_BITS'($urandom), 5'($urandom));
        end
        else if (pick < 90)
        begin
            if (live_slot.size() != 0 && $urandom_range(9) < 8)
            begin
                k = $urandom_range(live_slot.size() - 1);
                a = live_addr[k];
                if ($urandom_range(4) == 0)
                begin
                    a = a + (ADDRESS_BITS'($urandom) & span[ADDRESS_BITS-1:0]);
                end
                send(OP_FREE, a, live_slot[k], 5'($urandom));
                // keep some entries so that double frees happen too
                if ($urandom_range(3) != 0)
                begin
                    live_slot.delete(k);
                    live_addr.delete(k);
                end
            end
            else
            begin
                send(OP_FREE, rand_addr(), SLOT_BITS'($urandom), 5'($urandom));
            end
        end
        else
        begin
            send(OP_TRIM, rand_addr(), SLOT_BITS'($urandom),
                 ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(16)));
        end
    endtask

    initial
    begin
        int ratio_list[PHASES];
        int shift_list[PHASES];
        ratio_list = '{64, 1, 7, 33, 64, 2};
        shift_list = '{12, 0, 40, 5, 0, 63};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_RATIO;
        cfg_data       = '0;
        send_idle_pct  = 16;
        recv_stall_pct = 63;
        cur_shift      = 12;
        quiet_cycles   = 0;
        op_sent        = '{0, 0, 0, 0};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct  = (p < 2) ? 16 : (p < 4) ? 63 : 0;
            recv_stall_pct = (p < 2) ? 63 : (p < 4) ? 16 : 0;
            set_config(ratio_list[p], shift_list[p] % 64);
            if (p == 0)
            begin
                // empty table, then two chunks with edge bases
                send(OP_TRIM, '0, '0, 5'd0);
                send(OP_ALLOCATE, '0, '0, 5'd0);
                send(OP_FREE, '0, 4'd0, 5'd0);
                send(OP_RESERVE, '1, '0, 5'd0);
                send(OP_RESERVE, 48'hFFFF_FFFF_F000, '1, 5'd31);
                send(OP_RESERVE, '0, '0, 5'd31);
                send(OP_ALLOCATE, '0, '0, 5'd0);
                send(OP_ALLOCATE, '0, '0, 5'd0);
                send(OP_FREE, 48'h1000, 4'd1, 5'd0);
                send(OP_FREE, 48'h1000, 4'd1, 5'd0);
                send(OP_FREE, 48'h0FFF, 4'd1, 5'd0);
                send(OP_FREE, 48'h4_0000, 4'd1, 5'd0);
                send(OP_FREE, 48'h0, 4'd0, 5'd0);
                send(OP_FREE, '1, 4'd15, 5'd31);
                send(OP_TRIM, '0, '0, 5'd31);
                send(OP_TRIM, '0, '0, 5'd0);
                for (int i = 0; i < 8; i++)
                begin
                    send(OP_RESERVE, rand_addr(), '0, 5'd16);
                end
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_random();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        $display("covered %0d reserve, %0d allocate, %0d free, %0d trim requests",
                 op_sent[OP_RESERVE], op_sent[OP_ALLOCATE], op_sent[OP_FREE],
                 op_sent[OP_TRIM]);
        $display("over %0d settings; %0d results: %0d no memory, %0d invalid, %0d nothing to do",
                 PHASES, n_results, n_nomem, n_invalid, n_nothing);
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
design/bspa_pkg.sv
design/bspa_ctrl.sv
design/bspa_datapath.sv
design/bitmap_subpage_pool_allocator_core.sv
dv/bspa_pool_checker.sv
dv/tb_top.sv
